### src/bpm_pkg.sv
// ----------------------------------------------------------------------------
// bpm_pkg: shared types, codes and page mapping functions
// Page table entry layout, command and action codes, and the functions that
// work out frames and cards for a bank from the card registers.
// ----------------------------------------------------------------------------
package bpm_pkg;

  // command codes
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_MAP   = 2'd2;

  // action codes
  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_WRITE = 2'd2;
  localparam logic [1:0] ACT_RAND  = 2'd3;

  // card kinds
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_RAM  = 2'd1;

  // card codes held per page: 0-3 slot, 4 internal RAM, 7 none
  localparam logic [2:0] CARD_INT  = 3'd4;
  localparam logic [2:0] CARD_NONE = 3'd7;

  // register indexes
  localparam logic [2:0] REG_INT_RAM = 3'd4;
  localparam int unsigned NumRegs    = 5;

  // internal RAM
  localparam logic [7:0] INT_RAM_BANK  = 8'h20;
  localparam logic [8:0] INT_RAM_FRAME = 9'h040;   // 0x080000 in 8K units

  // generator
  localparam logic [15:0] SEED_RESET = 16'hac23;
  localparam logic [15:0] SEED_TAP1  = 16'hb4b8;
  localparam logic [15:0] SEED_TAP0  = 16'h00b8;

  typedef logic [NumRegs-1:0][7:0] card_regs_t;

  typedef struct packed {
    logic [8:0] frame;
    logic [7:0] bank;
    logic [2:0] card;
  } page_t;

  typedef page_t [7:0] page_tbl_t;

  function automatic logic [1:0] kind_of(card_regs_t regs, logic [2:0] idx);
    return regs[idx][1:0];
  endfunction

  function automatic logic [5:0] mask_of(card_regs_t regs, logic [2:0] idx);
    return regs[idx][7:2];
  endfunction

  function automatic logic is_int_bank(logic [7:0] bank);
    return bank[7:5] == 3'b001;
  endfunction

  function automatic logic [2:0] card_for_bank(card_regs_t regs, logic [7:0] bank);
    logic [2:0] slot;
    slot = {1'b0, bank[7:6]};
    if (is_int_bank(bank)) begin
      return CARD_INT;
    end
    return (kind_of(regs, slot) != KIND_NONE) ? slot : CARD_NONE;
  endfunction

  // frame (physical address bits 21:13) of the lower half of a 16K bank
  function automatic logic [8:0] bank_frame(card_regs_t regs, logic [7:0] bank);
    logic [2:0] slot;
    logic [5:0] m;
    logic [7:0] b16;
    slot = {1'b0, bank[7:6]};
    m = (kind_of(regs, slot) != KIND_NONE) ? mask_of(regs, slot) : 6'd0;
    if (is_int_bank(bank)) begin
      m = mask_of(regs, REG_INT_RAM);
    end
    b16 = ((bank[7:6] == 2'b00) ? (bank & 8'he0) : (bank & 8'hc0)) |
          (bank & {2'b00, m});
    return {b16, 1'b0};
  endfunction

  function automatic page_tbl_t map_segment(page_tbl_t tbl, card_regs_t regs,
                                            logic [1:0] seg, logic [7:0] bank,
                                            logic upper, logic ram);
    page_tbl_t  t;
    logic [8:0] f;
    logic [2:0] c;
    logic [7:0] even_bank;
    t = tbl;
    even_bank = bank & 8'hfe;
    f = bank_frame(regs, bank);
    c = card_for_bank(regs, bank);
    if (seg == 2'd0) begin
      if (!upper) begin
        if (ram) begin
          t[0] = '{frame: INT_RAM_FRAME, bank: INT_RAM_BANK, card: CARD_INT};
        end else begin
          t[0] = '{frame: 9'd0, bank: 8'd0,
                   card: (kind_of(regs, 3'd0) != KIND_NONE) ? 3'd0 : CARD_NONE};
        end
      end else begin
        t[1] = '{frame: bank_frame(regs, even_bank) + {8'd0, bank[0]},
                 bank: bank, card: c};
      end
    end else begin
      // frame is even, so the upper page's +1 never carries out
      t[{seg, 1'b0}] = '{frame: f, bank: bank, card: c};
      t[{seg, 1'b1}] = '{frame: f + 9'd1, bank: bank, card: c};
    end
    return t;
  endfunction

  // rebuild every page from its stored bank after a slot card change
  function automatic page_tbl_t recompute(page_tbl_t tbl, card_regs_t regs);
    page_tbl_t t;
    t = tbl;
    t = map_segment(t, regs, 2'd0, t[0].bank, 1'b0, t[0].bank == INT_RAM_BANK);
    t = map_segment(t, regs, 2'd0, t[1].bank, 1'b1, 1'b0);
    t = map_segment(t, regs, 2'd1, t[2].bank, 1'b0, 1'b0);
    t = map_segment(t, regs, 2'd2, t[4].bank, 1'b0, 1'b0);
    t = map_segment(t, regs, 2'd3, t[6].bank, 1'b0, 1'b0);
    return t;
  endfunction

  function automatic logic [15:0] seed_step(logic [15:0] s);
    return (s >> 1) ^ (s[0] ? SEED_TAP1 : SEED_TAP0);
  endfunction

endpackage

### src/banked_page_mapper.sv
// ----------------------------------------------------------------------------
// banked_page_mapper: 16-bit to 22-bit banked address translation
// Eight 8K page entries, slot card registers and a byte generator for
// reads of empty pages.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one command word: read, write
//   or map. Every word gives exactly one result word on the output channel
//   (out_valid/out_ready): phys_address, action and data.
//   Config channel (cfg_valid/cfg_ready) writes the card registers; it is
//   always ready. Writing a slot register rebuilds all eight page entries
//   in the same cycle. Write config only while no command is in flight.
// Pipeline and throughput:
//   A word is held in the input register, is translated by the page table
//   lookup, and lands in the result register, which raises out_valid. One
//   word per cycle is sustained while out_ready stays high; a map command
//   updates the table as it leaves the input register, so the next word
//   sees it.
// Reset: all pages hold no card, card registers clear, generator seed 0xac23.
// Stall: when out_ready is low the result holds, the input register keeps
//   one more word, and in_ready drops until the result is taken.
// ----------------------------------------------------------------------------
module banked_page_mapper
  import bpm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // command channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [15:0] address,
  input  logic [7:0]  write_data,
  input  logic [1:0]  segment,
  input  logic [7:0]  bank,
  input  logic        upper_half,
  input  logic        ram_select,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [21:0] phys_address,
  output logic [1:0]  action,
  output logic [7:0]  data,
  // config channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  // input register
  logic        s1_valid;
  logic [1:0]  s1_command;
  logic [15:0] s1_address;
  logic [7:0]  s1_write_data;
  logic [1:0]  s1_segment;
  logic [7:0]  s1_bank;
  logic        s1_upper_half;
  logic        s1_ram_select;
  logic        s1_advance;

  // state
  card_regs_t  cards, cards_next;
  page_tbl_t   pages, pages_next;
  logic [15:0] random_seed, random_seed_next;
  logic        slot_wr;

  // translation
  page_t       cur;
  logic [21:0] phys;
  logic        rand_step;
  logic [21:0] res_phys;
  logic [1:0]  res_action;
  logic [7:0]  res_data;

  assign cfg_ready  = 1'b1;
  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;

  // current page lookup
  assign cur       = pages[s1_address[15:13]];
  assign phys      = {cur.frame, s1_address[12:0]};
  assign rand_step = s1_advance && (s1_command == CMD_READ) && (cur.card == CARD_NONE);

  // config write, page table and generator next state
  always_comb begin
    cards_next = cards;
    slot_wr    = 1'b0;
    if (cfg_valid && (cfg_index <= REG_INT_RAM)) begin
      cards_next[cfg_index] = cfg_data;
      slot_wr = (cfg_index != REG_INT_RAM);
    end
    pages_next = pages;
    if (slot_wr) begin
      pages_next = recompute(pages, cards_next);
    end else if (s1_advance && (s1_command == CMD_MAP)) begin
      pages_next = map_segment(pages, cards, s1_segment, s1_bank,
                               s1_upper_half, s1_ram_select);
    end
    random_seed_next = rand_step ? seed_step(random_seed) : random_seed;
  end

  // result of the word in the input register
  always_comb begin
    res_phys   = 22'd0;
    res_action = ACT_NONE;
    res_data   = 8'd0;
    case (s1_command)
      CMD_READ: begin
        if (cur.card == CARD_NONE) begin
          res_action = ACT_RAND;
          res_data   = random_seed_next[15:8];
        end else begin
          res_action = ACT_READ;
          res_phys   = phys;
        end
      end
      CMD_WRITE: begin
        if ((cur.card <= CARD_INT) && (kind_of(cards, cur.card) == KIND_RAM)) begin
          res_action = ACT_WRITE;
          res_phys   = phys;
          res_data   = s1_write_data;
        end
      end
      default: begin
        res_action = ACT_NONE;
      end
    endcase
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      out_valid   <= 1'b0;
      cards       <= '0;
      random_seed <= SEED_RESET;
      for (int i = 0; i < 8; i++) begin
        pages[i] <= '{frame: 9'd0, bank: 8'd0, card: CARD_NONE};
      end
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (s1_advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      cards       <= cards_next;
      pages       <= pages_next;
      random_seed <= random_seed_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_command    <= command;
      s1_address    <= address;
      s1_write_data <= write_data;
      s1_segment    <= segment;
      s1_bank       <= bank;
      s1_upper_half <= upper_half;
      s1_ram_select <= ram_select;
    end
    if (s1_advance) begin
      phys_address <= res_phys;
      action       <= res_action;
      data         <= res_data;
    end
  end

  // checks
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> in_ready)
    else $error("input register empty but in_ready low");

  a_seed_only_on_empty_read: assert property (@(posedge clk) disable iff (rst)
    !rand_step |=> $stable(random_seed))
    else $error("generator stepped without an empty-page read");

  a_advance_gives_result: assert property (@(posedge clk) disable iff (rst)
    s1_advance |=> out_valid)
    else $error("word left input register without a result");

  a_rand_has_no_address: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (action == ACT_RAND || action == ACT_NONE)) |-> (phys_address == 22'd0))
    else $error("address given on a non-memory result");

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for banked_page_mapper
// Drives read, write and map words through the command channel and writes the
// card registers between phases while the pipe is empty. A page-table model
// kept inside the bench predicts the translated address, action and data for
// each accepted word. Every result word is checked in order against that
// prediction.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bpm_pkg::*;

  // register indexes of the slot cards; internal RAM is REG_INT_RAM
  localparam logic [2:0] REG_SLOT0 = 3'd0;
  localparam logic [2:0] REG_SLOT1 = 3'd1;
  localparam logic [2:0] REG_SLOT2 = 3'd2;
  localparam logic [2:0] REG_SLOT3 = 3'd3;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic [1:0]  seg;
    logic [7:0]  bnk;
    logic        upper;
    logic        ram;
  } cpu_access_t;

  typedef struct packed {
    logic [21:0] phys;
    logic [1:0]  act;
    logic [7:0]  dat;
  } xlat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  command = CMD_READ;
  logic [15:0] address = '0;
  logic [7:0]  write_data = '0;
  logic [1:0]  segment = '0;
  logic [7:0]  bank = '0;
  logic        upper_half = 1'b0;
  logic        ram_select = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [21:0] phys_address;
  logic [1:0]  action;
  logic [7:0]  data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;

  int send_idle_pct = 36;
  int recv_idle_pct = 70;
  int mismatches = 0;
  int stall_cycles = 0;
  xlat_t pending_xlats[$];

  banked_page_mapper u_dut (
    .clk, .rst,
    .in_valid, .in_ready, .command, .address, .write_data, .segment, .bank,
    .upper_half, .ram_select,
    .out_valid, .out_ready, .phys_address, .action, .data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Page-table model
  // ---------------------------------------------------------------------------
  logic [7:0]  card_reg [NumRegs];
  logic [7:0]  page_bank [8];
  logic [8:0]  page_frame [8];
  logic [2:0]  page_card [8];
  logic [15:0] noise_seed;

  function automatic logic [1:0] card_kind(logic [2:0] c);
    return card_reg[c][1:0];
  endfunction

  function automatic logic [2:0] owner_of_bank(logic [7:0] b);
    if (b[7:5] == 3'b001) return CARD_INT;
    return (card_kind({1'b0, b[7:6]}) != KIND_NONE) ? {1'b0, b[7:6]} : CARD_NONE;
  endfunction

  // 8K frame of the lower half of a 16K bank, mirrored by the chip mask
  function automatic logic [8:0] frame_of_bank(logic [7:0] b);
    logic [5:0] m;
    logic [7:0] b16;
    m = (card_kind({1'b0, b[7:6]}) != KIND_NONE) ? card_reg[{1'b0, b[7:6]}][7:2] : 6'd0;
    if (b[7:5] == 3'b001) m = card_reg[REG_INT_RAM][7:2];
    b16 = ((b < 8'h40) ? (b & 8'he0) : (b & 8'hc0)) | (b & {2'b00, m});
    return {b16, 1'b0};
  endfunction

  function automatic void set_page(int p, logic [8:0] f, logic [7:0] b, logic [2:0] c);
    page_frame[p] = f;
    page_bank[p]  = b;
    page_card[p]  = c;
  endfunction

  function automatic void load_segment(logic [1:0] seg, logic [7:0] b, logic upper,
                                       logic ram);
    if (seg == 2'd0) begin
      if (!upper) begin
        if (ram) begin
          set_page(0, INT_RAM_FRAME, INT_RAM_BANK, CARD_INT);
        end else begin
          set_page(0, 9'd0, 8'd0, (card_kind(3'd0) != KIND_NONE) ? 3'd0 : CARD_NONE);
        end
      end else begin
        set_page(1, frame_of_bank(b & 8'hfe) + {8'd0, b[0]}, b, owner_of_bank(b));
      end
    end else begin
      set_page(2 * seg, frame_of_bank(b), b, owner_of_bank(b));
      set_page(2 * seg + 1, frame_of_bank(b) + 9'd1, b, owner_of_bank(b));
    end
  endfunction

  // slot card change: every page is rebuilt from the bank it holds
  function automatic void rebuild_pages();
    load_segment(2'd0, page_bank[0], 1'b0, page_bank[0] == INT_RAM_BANK);
    load_segment(2'd0, page_bank[1], 1'b1, 1'b0);
    load_segment(2'd1, page_bank[2], 1'b0, 1'b0);
    load_segment(2'd2, page_bank[4], 1'b0, 1'b0);
    load_segment(2'd3, page_bank[6], 1'b0, 1'b0);
  endfunction

  function automatic logic [7:0] next_noise_byte();
    noise_seed = (noise_seed >> 1) ^ (noise_seed[0] ? SEED_TAP1 : SEED_TAP0);
    return noise_seed[15:8];
  endfunction

  function automatic void reset_pages();
    for (int i = 0; i < NumRegs; i++) card_reg[i] = 8'h00;
    for (int p = 0; p < 8; p++) set_page(p, 9'd0, 8'd0, CARD_NONE);
    noise_seed = SEED_RESET;
  endfunction

  function automatic void apply_card_write(logic [2:0] idx, logic [7:0] val);
    if (idx < NumRegs) begin
      card_reg[idx] = val;
      if (idx < REG_INT_RAM) rebuild_pages();
    end
  endfunction

  function automatic xlat_t translate_access(cpu_access_t a);
    xlat_t      r;
    logic [2:0] pg;
    logic [2:0] c;
    pg = a.addr[15:13];
    c = page_card[pg];
    r = '0;
    case (a.cmd)
      CMD_READ: begin
        if (c == CARD_NONE) begin
          r.act = ACT_RAND;
          r.dat = next_noise_byte();
        end else begin
          r.act  = ACT_READ;
          r.phys = {page_frame[pg], a.addr[12:0]};
        end
      end
      CMD_WRITE: begin
        // only RAM cards take writes; kind 3 counts as read-only
        if (c <= CARD_INT && card_kind(c) == KIND_RAM) begin
          r.act  = ACT_WRITE;
          r.phys = {page_frame[pg], a.addr[12:0]};
          r.dat  = a.wdata;
        end
      end
      CMD_MAP: load_segment(a.seg, a.bnk, a.upper, a.ram);
      default: ;
    endcase
    return r;
  endfunction

  function automatic void check_xlat();
    xlat_t want;
    if (pending_xlats.size() == 0) begin
      $display("%0t: unexpected result word: phys %h action %0d data %h",
               $time, phys_address, action, data);
      mismatches++;
    end else begin
      want = pending_xlats.pop_front();
      if (phys_address !== want.phys) begin
        $display("%0t: phys_address expected %h actual %h", $time, want.phys, phys_address);
        mismatches++;
      end
      if (action !== want.act) begin
        $display("%0t: action expected %0d actual %0d", $time, want.act, action);
        mismatches++;
      end
      if (data !== want.dat) begin
        $display("%0t: data expected %h actual %h", $time, want.dat, data);
        mismatches++;
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: model update on accepted words, check on result words
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      reset_pages();
    end else begin
      if (cfg_valid && cfg_ready) apply_card_write(cfg_index, cfg_data);
      if (in_valid && in_ready) begin
        pending_xlats.push_back(translate_access('{command, address, write_data, segment,
                                                  bank, upper_half, ram_select}));
      end
      if (out_valid && out_ready) check_xlat();
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog: too long with no word moving on any channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // valid stays up between back-to-back words; it only drops on an idle cycle
  task automatic send_word(input cpu_access_t a);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    command    <= a.cmd;
    address    <= a.addr;
    write_data <= a.wdata;
    segment    <= a.seg;
    bank       <= a.bnk;
    upper_half <= a.upper;
    ram_select <= a.ram;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain_pipe();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_xlats.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic cpu_access_t random_access();
    cpu_access_t a;
    int          r;
    r = $urandom_range(99);
    a.cmd   = (r < 45) ? CMD_READ : (r < 70) ? CMD_WRITE : (r < 95) ? CMD_MAP : CMD_UNUSED;
    a.addr  = 16'($urandom_range(16'hffff));
    a.wdata = 8'($urandom_range(8'hff));
    a.seg   = 2'($urandom_range(3));
    a.bnk   = 8'($urandom_range(8'hff));
    a.upper = 1'($urandom_range(1));
    a.ram   = 1'($urandom_range(1));
    return a;
  endfunction

  task automatic do_read(input logic [15:0] addr);
    cpu_access_t a;
    a = random_access();
    a.cmd  = CMD_READ;
    a.addr = addr;
    send_word(a);
  endtask

  task automatic do_write(input logic [15:0] addr, input logic [7:0] wd);
    cpu_access_t a;
    a = random_access();
    a.cmd   = CMD_WRITE;
    a.addr  = addr;
    a.wdata = wd;
    send_word(a);
  endtask

  task automatic do_map(input logic [1:0] seg, input logic [7:0] b, input logic upper,
                        input logic ram);
    cpu_access_t a;
    a = random_access();
    a.cmd   = CMD_MAP;
    a.seg   = seg;
    a.bnk   = b;
    a.upper = upper;
    a.ram   = ram;
    send_word(a);
  endtask

  function automatic logic [7:0] pick_card();
    case ($urandom_range(5))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom_range(8'hff));
    endcase
  endfunction

  task automatic shuffle_cards();
    drain_pipe();
    for (int r = 0; r < NumRegs; r++) begin
      if ($urandom_range(3) != 0) write_reg(3'(r), pick_card());
    end
    if ($urandom_range(3) == 0) begin
      write_reg(3'($urandom_range(7, NumRegs)), 8'($urandom_range(8'hff)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // no cards after reset: reads give generator bytes, writes go nowhere
  task automatic test_empty_reads();
    do_read(16'h0000);
    do_read(16'hffff);
    do_read(16'h2000);
    do_write(16'h4000, 8'hff);
    send_word('{CMD_UNUSED, 16'hffff, 8'hff, 2'd3, 8'hff, 1'b1, 1'b1});
  endtask

  // lower page: internal RAM or bank 0; upper page: half of a bank
  task automatic test_segment0_maps();
    drain_pipe();
    write_reg(REG_INT_RAM, 8'hfd);   // RAM, full mask
    write_reg(REG_SLOT0, 8'h05);     // RAM, mask 1
    write_reg(REG_SLOT1, 8'hfe);     // read-only, full mask
    write_reg(REG_SLOT2, 8'hff);     // kind 3, full mask
    write_reg(REG_SLOT3, 8'h01);     // RAM, no mask
    do_map(2'd0, 8'h00, 1'b0, 1'b1);
    do_read(16'h0000);
    do_write(16'h1fff, 8'ha5);
    do_map(2'd0, 8'h7f, 1'b0, 1'b0);
    do_write(16'h0abc, 8'h00);
    do_map(2'd0, 8'h21, 1'b1, 1'b0);
    do_read(16'h3fff);
    do_map(2'd0, 8'hff, 1'b1, 1'b0);
    do_read(16'h2000);
  endtask

  // whole-bank segments on read-only, kind 3 and unmasked RAM cards
  task automatic test_slot_segments();
    do_map(2'd1, 8'h40, 1'b0, 1'b0);
    do_read(16'h4000);
    do_write(16'h7fff, 8'h3c);
    do_map(2'd2, 8'hbf, 1'b1, 1'b1);
    do_write(16'h8000, 8'hc3);
    do_read(16'hbfff);
    do_map(2'd3, 8'hc5, 1'b0, 1'b0);
    do_write(16'hffff, 8'h81);
  endtask

  // card removal remaps pages; read-only internal RAM ignores writes
  task automatic test_card_changes();
    drain_pipe();
    write_reg(REG_SLOT0, 8'h00);
    write_reg(REG_INT_RAM, 8'h02);
    for (int r = NumRegs; r < 8; r++) write_reg(3'(r), 8'hff);
    do_read(16'h0000);
    do_map(2'd0, 8'h00, 1'b0, 1'b1);
    do_write(16'h0100, 8'h5a);
    do_read(16'h0100);
    drain_pipe();
    write_reg(REG_SLOT3, 8'h00);
    do_read(16'he000);
  endtask

  task automatic test_random_traffic(input int n_words);
    for (int i = 0; i < n_words; i++) begin
      if (i % 50 == 0) shuffle_cards();
      send_word(random_access());
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_empty_reads();
    test_segment0_maps();
    test_slot_segments();
    test_card_changes();
    test_random_traffic(200);
    send_idle_pct = 70;
    recv_idle_pct = 36;
    test_random_traffic(200);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(200);
    drain_pipe();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_xlats.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
